[design/pfpcw_pkg.sv]
`default_nettype none

package pfpcw_pkg;

	// Default table geometry.
	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int COUNT_BITS_DEF    = 16;

	// Fixed field widths of the stream and configuration ports.
	localparam int ID_BITS       = 64;
	localparam int OUT_CNT_BITS  = 16;
	localparam int MARK_BITS     = 16;
	localparam int CFG_ADDR_BITS = 1;

	// Operation codes carried in the low bits of s_tuser.
	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_POP   = 2'd1,
		ACT_QUERY = 2'd2
	} action_t;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_BITS-1:0] REG_LOW_MARK       = 1'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_TRIGGER_ENABLE = 1'd1;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

endpackage

`default_nettype wire

[design/per_flow_packet_count_watermark_core.sv]
`default_nettype none

// Per-flow queued-packet counter with a low-mark watermark. Each input
// transaction names a 64-bit connection id and an operation (push, pop or
// query); the block looks the id up in a table of TABLE_ENTRIES entries and
// returns exactly one result transaction with the resulting count and the
// limit, low-trigger and table-full flags. The lookup is a linear scan with a
// single shared 64-bit comparator reading one table entry per cycle from the
// entry memory. An accepted transaction then passes through ST_SCAN, which
// reads every table entry in turn, ST_DRAIN, which compares the last entry
// read, and ST_UPDATE, which writes the table and loads the result into the
// output register. s_tready stays low during that time and returns the cycle
// after, so a new transaction is taken only once the last one is through.
// The result sits in its own output register, so the next transaction can
// be accepted while a result still waits for m_tready; only the final table
// write waits for the output register to be free, and while it waits that
// transaction stays in ST_UPDATE.
// Configuration writes take effect on the clock edge at which cfg_we is high
// and should be issued only while the block is idle. No clearing pass is
// needed after reset: entry validity lives in flip-flops that reset clears at
// once.
module per_flow_packet_count_watermark_core
	import pfpcw_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// Configuration write port.
	input  wire logic                     cfg_we,
	input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  wire logic [MARK_BITS-1:0]     cfg_data,
	// Input stream.
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [ID_BITS-1:0]       s_tdata,   // [63:0] net_id
	input  wire logic [2:0]               s_tuser,   // [1:0] action, [2] report_limit
	// Result stream.
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [OUT_CNT_BITS-1:0]       m_tdata,   // [15:0] count
	output logic [2:0]                    m_tuser    // [0] limit_reached, [1] low_trigger,
	                                                 // [2] table_full
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	// Width wide enough to compare a stored count against the 16-bit mark.
	localparam int CW = (COUNT_BITS > MARK_BITS) ? COUNT_BITS : MARK_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
	localparam logic [IW-1:0]         LAST_IDX  = IW'(TABLE_ENTRIES - 1);

	typedef struct packed {
		logic [ID_BITS-1:0]    id;
		logic [COUNT_BITS-1:0] cnt;
		logic                  marked;
	} entry_t;

	// Configuration registers.
	logic [MARK_BITS-1:0] low_mark_q;
	logic                 trig_en_q;

	// Sequencer and the transaction being worked on.
	state_t               state_q;
	logic [IW-1:0]        scan_idx_q;
	logic [ID_BITS-1:0]   id_q;
	logic [1:0]           action_q;
	logic                 report_q;

	// Entry table: validity in flip-flops, the rest in a memory.
	logic [TABLE_ENTRIES-1:0] valid_q;
	entry_t                   mem [TABLE_ENTRIES];
	entry_t                   rd_s1;
	logic                     cmp_vld_s1;
	logic [IW-1:0]            cmp_idx_s1;

	// Scan results.
	logic                 hit_q;
	logic [IW-1:0]        hit_idx_q;
	entry_t               hit_ent_q;
	logic                 free_q;
	logic [IW-1:0]        free_idx_q;

	// Output register.
	logic                    m_valid_q;
	logic [OUT_CNT_BITS-1:0] out_cnt_q;
	logic [2:0]              out_flags_q;

	// Update-step signals.
	logic                  upd_go;
	logic                  armed;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] cnt_dec;
	logic [COUNT_BITS-1:0] res_cnt;
	logic                  res_limit;
	logic                  res_trig;
	logic                  res_full;
	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	entry_t                mem_wdata;
	logic                  vset;
	logic                  vclr;
	logic [IW-1:0]         vidx;
	logic [CW-1:0]         low_ext;
	logic [CW-1:0]         res_ext;
	logic                  id_match;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_cnt_q;
	assign m_tuser  = out_flags_q;

	assign upd_go   = (state_q == ST_UPDATE) && (!m_valid_q || m_tready);
	assign armed    = trig_en_q && (low_mark_q != '0);
	assign low_ext  = CW'(low_mark_q);
	assign cnt_inc  = (hit_ent_q.cnt == COUNT_MAX) ? hit_ent_q.cnt : hit_ent_q.cnt + COUNT_ONE;
	assign cnt_dec  = hit_ent_q.cnt - COUNT_ONE;
	assign res_ext  = CW'(res_cnt);
	assign id_match = cmp_vld_s1 && valid_q[cmp_idx_s1] && (rd_s1.id == id_q);

	// Decide the result and the table write once the scan is complete.
	always_comb begin
		res_cnt   = '0;
		res_limit = 1'b0;
		res_trig  = 1'b0;
		res_full  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = hit_idx_q;
		mem_wdata = hit_ent_q;
		vset      = 1'b0;
		vclr      = 1'b0;
		vidx      = hit_idx_q;
		unique case (action_q)
			ACT_PUSH: begin
				if (hit_q) begin
					res_cnt          = cnt_inc;
					res_limit        = report_q && armed && (CW'(cnt_inc) >= low_ext);
					mem_we           = upd_go;
					mem_wdata.cnt    = cnt_inc;
					mem_wdata.marked = hit_ent_q.marked | res_limit;
				end else if (free_q) begin
					res_cnt          = COUNT_ONE;
					mem_we           = upd_go;
					mem_waddr        = free_idx_q;
					mem_wdata.id     = id_q;
					mem_wdata.cnt    = COUNT_ONE;
					mem_wdata.marked = 1'b0;
					vset             = upd_go;
					vidx             = free_idx_q;
				end else begin
					res_full = 1'b1;
				end
			end
			ACT_POP: begin
				if (hit_q) begin
					if (hit_ent_q.cnt <= COUNT_ONE) begin
						// Last packet of the flow: free the entry.
						res_trig = hit_ent_q.marked && armed;
						vclr     = upd_go;
					end else begin
						res_cnt          = cnt_dec;
						res_trig         = hit_ent_q.marked && armed &&
						                   (CW'(cnt_dec) < low_ext);
						mem_we           = upd_go;
						mem_wdata.cnt    = cnt_dec;
						mem_wdata.marked = hit_ent_q.marked & ~res_trig;
					end
				end
			end
			default: begin
				// Query, and the unused code that behaves as one.
				if (hit_q) begin
					res_cnt = hit_ent_q.cnt;
				end
			end
		endcase
	end

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_s1 <= mem[scan_idx_q];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			id_q     <= s_tdata;
			action_q <= s_tuser[1:0];
			report_q <= s_tuser[2];
		end
		cmp_idx_s1 <= scan_idx_q;
		if (id_match && !hit_q) begin
			hit_idx_q <= cmp_idx_s1;
			hit_ent_q <= rd_s1;
		end
		if ((state_q == ST_SCAN) && !free_q && !valid_q[scan_idx_q]) begin
			free_idx_q <= scan_idx_q;
		end
		if (upd_go) begin
			// Counts wider than the result field saturate at its maximum.
			out_cnt_q   <= (res_ext > CW'({OUT_CNT_BITS{1'b1}})) ?
			               {OUT_CNT_BITS{1'b1}} : res_ext[OUT_CNT_BITS-1:0];
			out_flags_q <= {res_full, res_trig, res_limit};
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			valid_q    <= '0;
			m_valid_q  <= 1'b0;
			low_mark_q <= '0;
			trig_en_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_LOW_MARK:       low_mark_q <= cfg_data;
					REG_TRIGGER_ENABLE: trig_en_q  <= cfg_data[0];
					default:            ;
				endcase
			end

			cmp_vld_s1 <= (state_q == ST_SCAN);
			if (id_match) begin
				hit_q <= 1'b1;
			end
			if ((state_q == ST_SCAN) && !valid_q[scan_idx_q]) begin
				free_q <= 1'b1;
			end

			if (vset) begin
				valid_q[vidx] <= 1'b1;
			end else if (vclr) begin
				valid_q[vidx] <= 1'b0;
			end

			if (upd_go) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						scan_idx_q <= '0;
						hit_q      <= 1'b0;
						free_q     <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					// The last entry read is compared in this cycle.
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (upd_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[design/pfpcw_checker.sv]
`default_nettype none

module pfpcw_checker
	import pfpcw_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    s_tvalid,
	input wire logic                    s_tready,
	input wire logic                    m_tvalid,
	input wire logic                    m_tready,
	input wire logic [OUT_CNT_BITS-1:0] m_tdata,
	input wire logic [2:0]              m_tuser
);

	// A held result keeps its contents until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// The block works on one transaction at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a lookup is in progress");

	// At most one status flag applies to a result.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones(m_tuser) <= 1)
		else $error("more than one status flag set");

	// A dropped insert reports a zero count.
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tdata == '0)
		else $error("table full with nonzero count");

	// A limit is only reported for a live entry.
	a_limit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata != '0)
		else $error("limit reported with zero count");

endmodule

bind per_flow_packet_count_watermark_core pfpcw_checker u_pfpcw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
